### sv/cwt_pkg.sv
// Package: shared constants, types and overflow helpers for the cumulative weight tree.
package cwt_pkg;

  localparam int TREE_DEPTH  = 10;
  localparam int SUM_WIDTH   = 48;
  localparam int NODE_AW     = TREE_DEPTH + 1;
  localparam int NODES       = (1 << NODE_AW) - 1;
  localparam int BINS        = NODES - 1;
  localparam int ROOT        = (1 << TREE_DEPTH) - 1;
  localparam int FIRST_STEP  = 1 << (TREE_DEPTH - 1);
  localparam int RAM_DEPTH   = 1 << NODE_AW;
  localparam int STEP_W      = TREE_DEPTH;
  localparam int BIN_W       = 11;
  localparam int KEY_W       = 32;
  localparam int OUT_W       = 48;
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = QAW + 1;

  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef logic [NODE_AW-1:0]          node_t;
  typedef logic [STEP_W-1:0]           step_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;

  typedef enum logic [1:0] {
    KIND_SEARCH,
    KIND_ADD,
    KIND_SKIP
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [BIN_W-1:0]        bin;
    logic signed [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_RD,
    ST_S_EX,
    ST_W_RD,
    ST_W_EX,
    ST_T_RD,
    ST_T_EX,
    ST_F_RD,
    ST_F_EX
  } state_t;

  function automatic logic add_ov(input sum_t a, input sum_t b, input sum_t r);
    return (a[SUM_WIDTH-1] == b[SUM_WIDTH-1]) && (r[SUM_WIDTH-1] != a[SUM_WIDTH-1]);
  endfunction

  function automatic logic sub_ov(input sum_t a, input sum_t b, input sum_t r);
    return (a[SUM_WIDTH-1] != b[SUM_WIDTH-1]) && (r[SUM_WIDTH-1] != a[SUM_WIDTH-1]);
  endfunction

endpackage

### sv/cwt_if.sv
// Interfaces: request and response channels of the cumulative weight tree.
interface cwt_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [10:0]       bin_index;
  logic signed [31:0] operand_value;
  modport source(output valid, opcode, bin_index, operand_value, input ready);
  modport sink(input valid, opcode, bin_index, operand_value, output ready);
endinterface

interface cwt_out_if;
  logic              valid;
  logic              ready;
  logic [10:0]       found_bin;
  logic signed [47:0] bin_weight;
  logic signed [47:0] total_weight;
  logic              overflow;
  modport source(output valid, found_bin, bin_weight, total_weight, overflow, input ready);
  modport sink(input valid, found_bin, bin_weight, total_weight, overflow, output ready);
endinterface

### sv/cwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/cwt_front.sv
// Front end: classifies request beats and holds them in a short queue for the engine.
module cwt_front import cwt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cwt_in_if.sink    req,
  input  back_ctl_t ctl,
  output q_t        q
);
  item_t            entry [QUEUE_DEPTH];
  item_t            cls;
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  always_comb begin
    cls.bin = req.bin_index;
    cls.key = req.operand_value;
    if (req.opcode == OP_SEARCH) begin
      cls.kind = KIND_SEARCH;
    end else if (32'(req.bin_index) < BINS) begin
      cls.kind = KIND_ADD;
    end else begin
      cls.kind = KIND_SKIP;
    end
  end

  assign req.ready = (count != CNT_W'(QUEUE_DEPTH)) && !ctl.busy;
  assign push      = req.valid && req.ready;
  assign q.valid   = (count != '0);
  assign q.item    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (ctl.pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + CNT_W'(push) - CNT_W'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls;
    end
  end
endmodule

### sv/cwt_back.sv
// Back end: clears the stores, walks the tree for searches and adds, drives the response.
module cwt_back import cwt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_t        q,
  output back_ctl_t ctl,
  cwt_out_if.source rsp
);
  state_t state, state_next;

  node_t                   clr_addr;
  node_t                   j, i, bin_r;
  step_t                   step;
  logic                    phase_l;
  sum_t                    run, amt, weight, total;
  logic signed [KEY_W-1:0] key;
  node_t                   best;
  logic                    ov, ov_next;
  logic                    is_search;

  logic                    out_vld;
  logic [BIN_W-1:0]        out_bin;
  logic signed [OUT_W-1:0] out_weight, out_total;
  logic                    out_ov;

  logic  node_we, wt_we;
  node_t node_waddr, node_raddr, wt_waddr, wt_raddr;
  sum_t  node_wdata, node_rdata, wt_wdata, wt_rdata;

  sum_t  run_sum, node_sum, node_dif, wt_sum, tot_sum, key_w;
  logic  key_lt, j_ge, j_eq, j_lt, do_add, do_sub, ph2, fin;
  node_t step_n, f_addr;

  cwt_ram #(.WIDTH(SUM_WIDTH), .DEPTH(RAM_DEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  cwt_ram #(.WIDTH(SUM_WIDTH), .DEPTH(RAM_DEPTH)) u_wt_ram (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  assign key_w    = SUM_WIDTH'(key);
  assign run_sum  = run + node_rdata;
  assign node_sum = node_rdata + amt;
  assign node_dif = node_rdata - amt;
  assign wt_sum   = wt_rdata + amt;
  assign tot_sum  = total + amt;
  assign key_lt   = key_w < run_sum;
  assign step_n   = node_t'(step);
  assign f_addr   = j - step_n;
  assign j_ge     = (j >= i);
  assign j_eq     = (j == i);
  assign j_lt     = (j < i);
  assign do_add   = !phase_l && j_ge;
  assign ph2      = phase_l || do_add;
  assign do_sub   = ph2 && j_lt;

  assign ctl.busy = (state == ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (ctl.pop) begin
          unique case (q.item.kind)
            KIND_SEARCH: state_next = ST_S_RD;
            KIND_ADD:    state_next = ST_W_RD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_S_RD: state_next = ST_S_EX;
      ST_S_EX: state_next = (step != '0) ? ST_S_RD : ST_IDLE;
      ST_W_RD: state_next = ST_W_EX;
      ST_W_EX: state_next = ST_T_RD;
      ST_T_RD: state_next = ST_T_EX;
      ST_T_EX: begin
        if (!j_eq) state_next = ST_T_RD;
        else if (step != '0) state_next = ST_F_RD;
        else state_next = ST_IDLE;
      end
      ST_F_RD: state_next = ST_F_EX;
      ST_F_EX: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.pop    = 1'b0;
    node_we    = 1'b0;
    node_waddr = j;
    node_wdata = node_sum;
    node_raddr = j;
    wt_we      = 1'b0;
    wt_waddr   = bin_r;
    wt_wdata   = wt_sum;
    wt_raddr   = bin_r;
    ov_next    = ov;
    fin        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_addr;
        node_wdata = '0;
        wt_we      = 1'b1;
        wt_waddr   = clr_addr;
        wt_wdata   = '0;
      end
      ST_IDLE: begin
        ctl.pop = q.valid && !out_vld;
        fin     = ctl.pop && (q.item.kind == KIND_SKIP);
        if (ctl.pop && (q.item.kind == KIND_ADD)) begin
          ov_next = (KEY_W'(sum_t'(q.item.key)) != q.item.key);
        end else begin
          ov_next = 1'b0;
        end
      end
      ST_S_EX: begin
        ov_next = ov | add_ov(run, node_rdata, run_sum);
        fin     = (step == '0);
      end
      ST_W_EX: begin
        wt_we   = 1'b1;
        ov_next = ov | add_ov(wt_rdata, amt, wt_sum) | add_ov(total, amt, tot_sum);
      end
      ST_T_EX: begin
        node_we    = do_add || do_sub;
        node_wdata = do_add ? node_sum : node_dif;
        if (do_add) ov_next = ov | add_ov(node_rdata, amt, node_sum);
        else if (do_sub) ov_next = ov | sub_ov(node_rdata, amt, node_dif);
        fin        = j_eq && (step == '0);
      end
      ST_F_RD: node_raddr = f_addr;
      ST_F_EX: begin
        node_we    = 1'b1;
        node_waddr = f_addr;
        node_wdata = node_dif;
        ov_next    = ov | sub_ov(node_rdata, amt, node_dif);
        fin        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      total    <= '0;
      out_vld  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + NODE_AW'(1);
      if (state == ST_W_EX) total <= tot_sum;
      if (fin) out_vld <= 1'b1;
      else if (rsp.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ov <= ov_next;
    unique case (state)
      ST_IDLE: begin
        if (ctl.pop) begin
          key       <= q.item.key;
          amt       <= SUM_WIDTH'(q.item.key);
          bin_r     <= node_t'(q.item.bin);
          i         <= node_t'(q.item.bin) + NODE_AW'(1);
          j         <= NODE_AW'(ROOT);
          step      <= STEP_W'(FIRST_STEP);
          run       <= '0;
          best      <= '0;
          phase_l   <= 1'b0;
          weight    <= '0;
          is_search <= (q.item.kind == KIND_SEARCH);
        end
      end
      ST_S_EX: begin
        run <= run_sum;
        if (step != '0) begin
          if (key_lt) begin
            j <= j - step_n;
          end else begin
            best <= j;
            j    <= j + step_n;
          end
          step <= step >> 1;
        end
      end
      ST_W_EX: weight <= wt_sum;
      ST_T_EX: begin
        phase_l <= do_sub ? 1'b0 : ph2;
        if (!j_eq) begin
          j    <= j_lt ? j + step_n : j - step_n;
          step <= step >> 1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_ov    <= ov_next;
      out_total <= OUT_W'((state == ST_W_EX) ? tot_sum : total);
      if ((state == ST_S_EX) && is_search) begin
        out_bin <= BIN_W'(key_lt ? best : j);
      end else begin
        out_bin <= '0;
      end
      out_weight <= (state == ST_IDLE) ? '0 : OUT_W'(weight);
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.found_bin    = out_bin;
  assign rsp.bin_weight   = out_weight;
  assign rsp.total_weight = out_total;
  assign rsp.overflow     = out_ov;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (state == ST_IDLE) && !out_vld)
    else $error("pop outside idle");
  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T_EX) && !j_eq |-> step != '0)
    else $error("tree walk ran out of levels");
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |=> (state != ST_CLEAR))
    else $error("clear pass restarted");
  a_node_range: assert property (@(posedge clk) disable iff (rst)
    node_we && (state != ST_CLEAR) |-> (32'(node_waddr) < NODES))
    else $error("node write out of range");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    fin |-> !out_vld)
    else $error("result overwrote pending beat");
`endif
endmodule

### sv/cumulative_weight_tree.sv
// Top level: cumulative weight tree with decoupled front queue and tree engine.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    opcode, bin_index, operand_value
//  rsp      out  valid/ready    found_bin, bin_weight, total_weight, overflow
//
// After reset a clearing pass zeroes both stores, holding req.ready low.
// Search: one dependent node read per level.
// Add: a read-modify-write per path node.
// An add to a bin out of range is skipped without a tree walk. The front queue
// holds two beats, so req takes up to two while a response waits on rsp.ready.
module cumulative_weight_tree import cwt_pkg::*; (
  input logic       clk,
  input logic       rst,
  cwt_in_if.sink    req,
  cwt_out_if.source rsp
);
  q_t        q;
  back_ctl_t ctl;

  cwt_front u_front (
    .clk(clk), .rst(rst), .req(req), .ctl(ctl), .q(q)
  );

  cwt_back u_back (
    .clk(clk), .rst(rst), .q(q), .ctl(ctl), .rsp(rsp)
  );
endmodule
